FILE: design/stepper_homing_sequencer_unit_macros.svh
// Assertion macros used by the homing sequencer checker.
`ifndef STEPPER_HOMING_SEQUENCER_UNIT_MACROS_SVH
`define STEPPER_HOMING_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define SHS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("homing sequencer assertion failed");

// Next-cycle implication, sampled on clock and disabled during reset.
`define SHS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("homing sequencer assertion failed");

`endif

FILE: design/shs_pkg.sv
// Types, constants and register map of the stepper homing sequencer.
package shs_pkg;

   localparam int ELAPSED_WIDTH = 20;
   localparam int SINCE_WIDTH   = 16;
   localparam int TIMEOUT_WIDTH = 20;
   localparam int STEP_WIDTH    = 16;
   localparam int CMP_WIDTH     = (ELAPSED_WIDTH > TIMEOUT_WIDTH) ? ELAPSED_WIDTH
                                                                 : TIMEOUT_WIDTH;
   localparam int ADDR_WIDTH    = 4;
   localparam int DATA_WIDTH    = 32;

   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(30000);
   localparam logic [STEP_WIDTH-1:0]    FAST_RESET    = STEP_WIDTH'(5);
   localparam logic [STEP_WIDTH-1:0]    SLOW_RESET    = STEP_WIDTH'(20);

   typedef enum logic [2:0] {
      MODE_INIT   = 3'd0,
      MODE_HOMING = 3'd1,
      MODE_RUN    = 3'd2,
      MODE_JUMP   = 3'd3,
      MODE_ERROR  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_ESCAPE = 2'd0,
      PHASE_SEARCH = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT = 2'd0,
      REG_FAST    = 2'd1,
      REG_SLOW    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic restart;
      logic sensor_detected;
      logic at_home_position;
   } req_type;

   typedef struct packed {
      logic       step_pulse;
      logic       motor_off;
      logic [2:0] mode;
      logic [1:0] phase;
   } rsp_type;

   typedef struct packed {
      logic [TIMEOUT_WIDTH-1:0] homing_timeout_ms;
      logic [STEP_WIDTH-1:0]    fast_step_interval_ms;
      logic [STEP_WIDTH-1:0]    slow_step_interval_ms;
   } cfg_type;

   typedef struct packed {
      mode_type                 mode;
      phase_type                phase;
      logic                     started;
      logic [ELAPSED_WIDTH-1:0] elapsed;
      logic [SINCE_WIDTH-1:0]   since;
   } state_type;

endpackage

FILE: design/stepper_homing_sequencer_unit.sv
// Top level of the stepper homing sequencer: handshake, registers and CSR port.
//
// Each request transfer is one millisecond tick carrying the restart flag and the two
// home-sensor levels; each tick yields exactly one response transfer with the step
// command, motor disable, top mode and homing phase after the tick. While rsp_ready is
// high the block takes one tick per clock cycle: a tick is captured in an input register,
// its whole update is done by the combinational step logic in the next cycle, and the
// result lands in an output register. A response is offered once its tick has passed
// through the input and output registers and transfers when rsp_ready is high. The output
// register separates the two sides, so one more request is taken while a finished
// response waits for rsp_ready; after that the input stalls until the response transfers.
// The three settings
// (homing timeout, fast and slow step intervals, in milliseconds) sit behind an APB-style
// port at byte addresses 0, 4 and 8; writes to addresses 12 to 15 are ignored and read back
// zero. Change them only while no tick is in flight. A restart returns only the top mode
// to init; an unfinished homing keeps its phase and counters and resumes from there.
module stepper_homing_sequencer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  shs_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output shs_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [shs_pkg::ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [shs_pkg::DATA_WIDTH-1:0]  csr_pwdata,
   output logic [shs_pkg::DATA_WIDTH-1:0]  csr_prdata,
   output logic                            csr_pready
);

   // Input stage.
   logic               in_valid_ff;
   logic               in_valid_in;
   shs_pkg::req_type   in_data_ff;

   // Sequencer state, updated once per processed tick.
   shs_pkg::state_type state_ff;
   shs_pkg::state_type state_in;

   // Output stage.
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   shs_pkg::rsp_type   rsp_data_ff;
   shs_pkg::rsp_type   rsp_data_in;

   // Settings.
   shs_pkg::cfg_type   cfg_ff;
   shs_pkg::cfg_type   cfg_in;

   logic               req_xfer;
   logic               advance;
   logic               csr_write;
   logic [1:0]         csr_index;

   // A tick moves from the input register to the output register whenever the output
   // register is empty or is being emptied in this cycle.
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign req_xfer    = req_valid && req_ready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   shs_step u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .req       (in_data_ff),
      .nxt_state (state_in),
      .rsp       (rsp_data_in)
   );

   // Register file: writes complete in the access phase; pready is tied high.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            shs_pkg::REG_TIMEOUT:
               cfg_in.homing_timeout_ms = csr_pwdata[shs_pkg::TIMEOUT_WIDTH-1:0];
            shs_pkg::REG_FAST:
               cfg_in.fast_step_interval_ms = csr_pwdata[shs_pkg::STEP_WIDTH-1:0];
            shs_pkg::REG_SLOW:
               cfg_in.slow_step_interval_ms = csr_pwdata[shs_pkg::STEP_WIDTH-1:0];
            default: begin
               // Unmapped address: the write is dropped.
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         shs_pkg::REG_TIMEOUT:
            csr_prdata = shs_pkg::DATA_WIDTH'(cfg_ff.homing_timeout_ms);
         shs_pkg::REG_FAST:
            csr_prdata = shs_pkg::DATA_WIDTH'(cfg_ff.fast_step_interval_ms);
         shs_pkg::REG_SLOW:
            csr_prdata = shs_pkg::DATA_WIDTH'(cfg_ff.slow_step_interval_ms);
         default:
            csr_prdata = '0;
      endcase
   end

   // Control state and settings, synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.mode    <= shs_pkg::MODE_INIT;
         state_ff.phase   <= shs_pkg::PHASE_ESCAPE;
         state_ff.started <= 1'b0;
         state_ff.elapsed <= '0;
         state_ff.since   <= '0;
         cfg_ff.homing_timeout_ms     <= shs_pkg::TIMEOUT_RESET;
         cfg_ff.fast_step_interval_ms <= shs_pkg::FAST_RESET;
         cfg_ff.slow_step_interval_ms <= shs_pkg::SLOW_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_xfer) in_data_ff <= req_data;
      if (advance)  rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/shs_step.sv
// Next-state and result logic for one millisecond tick of the homing sequencer.
module shs_step (
   input  shs_pkg::state_type cur_state,
   input  shs_pkg::cfg_type   cfg,
   input  shs_pkg::req_type   req,
   output shs_pkg::state_type nxt_state,
   output shs_pkg::rsp_type   rsp
);

   shs_pkg::state_type nxt;
   logic               step;
   logic               off;

   always_comb begin
      nxt  = cur_state;
      step = 1'b0;
      off  = 1'b0;

      // Both counters run while homing is in progress, saturating at all ones.
      if (cur_state.started) begin
         if (cur_state.elapsed != '1) nxt.elapsed = cur_state.elapsed + 1'b1;
         if (cur_state.since != '1)   nxt.since   = cur_state.since + 1'b1;
      end

      if (req.restart) nxt.mode = shs_pkg::MODE_INIT;

      case (nxt.mode)
         shs_pkg::MODE_INIT: begin
            nxt.mode = shs_pkg::MODE_HOMING;
         end
         shs_pkg::MODE_HOMING: begin
            if (!nxt.started) begin
               nxt.started = 1'b1;
               nxt.elapsed = '0;
               nxt.since   = '0;
               nxt.phase   = req.sensor_detected ? shs_pkg::PHASE_ESCAPE
                                                 : shs_pkg::PHASE_SEARCH;
            end
            if (shs_pkg::CMP_WIDTH'(nxt.elapsed) >=
                shs_pkg::CMP_WIDTH'(cfg.homing_timeout_ms)) begin
               off         = 1'b1;
               nxt.mode    = shs_pkg::MODE_ERROR;
               nxt.started = 1'b0;
               nxt.phase   = shs_pkg::PHASE_ESCAPE;
            end else begin
               case (nxt.phase)
                  shs_pkg::PHASE_ESCAPE: begin
                     if (!req.sensor_detected) begin
                        nxt.phase = shs_pkg::PHASE_SEARCH;
                        nxt.since = '0;
                     end else if (nxt.since >= cfg.fast_step_interval_ms) begin
                        step      = 1'b1;
                        nxt.since = '0;
                     end
                  end
                  shs_pkg::PHASE_SEARCH: begin
                     if (req.at_home_position) begin
                        off       = 1'b1;
                        nxt.phase = shs_pkg::PHASE_DONE;
                     end else if (nxt.since >= cfg.slow_step_interval_ms) begin
                        step      = 1'b1;
                        nxt.since = '0;
                     end
                  end
                  default: begin
                     // Done: homing is finished, hand over to run.
                     nxt.started = 1'b0;
                     nxt.phase   = shs_pkg::PHASE_ESCAPE;
                     nxt.mode    = shs_pkg::MODE_RUN;
                  end
               endcase
            end
         end
         default: begin
            // Run, jump and error hold.
         end
      endcase
   end

   assign nxt_state      = nxt;
   assign rsp.step_pulse = step;
   assign rsp.motor_off  = off;
   assign rsp.mode       = nxt.mode;
   assign rsp.phase      = nxt.phase;

endmodule

FILE: design/shs_checker.sv
// Port-level checker for the stepper homing sequencer, bound to the top level.
`include "stepper_homing_sequencer_unit_macros.svh"

module shs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input shs_pkg::rsp_type rsp_data
);

   logic step_seen;
   logic off_seen;
   logic at_done;
   logic done_seen;
   logic in_homing;
   logic in_error;

   assign step_seen = rsp_valid && rsp_data.step_pulse;
   assign off_seen  = rsp_valid && rsp_data.motor_off;
   assign at_done   = (rsp_data.phase == shs_pkg::PHASE_DONE);
   assign done_seen = rsp_valid && at_done;
   assign in_homing = (rsp_data.mode == shs_pkg::MODE_HOMING);
   assign in_error  = (rsp_data.mode == shs_pkg::MODE_ERROR);

   // A stalled response stays offered and unchanged.
   `SHS_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A step is only commanded while homing, and never together with motor disable.
   `SHS_ASSERT_IMP(a_step_homing, step_seen, in_homing && !rsp_data.motor_off)

   // Motor disable comes only from a timeout or from reaching home.
   `SHS_ASSERT_IMP(a_off_cause, off_seen, in_error || at_done)

   // The done phase is only ever reported while still homing.
   `SHS_ASSERT_IMP(a_done_homing, done_seen, in_homing)

endmodule

bind stepper_homing_sequencer_unit shs_checker u_shs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
